@@ design/ctt_pkg.sv @@
// ----------------------------------------------------------------------------
// ctt_pkg
// Shared types and constants for the countdown timer table: sizes, opcodes,
// result kinds, entry states and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package ctt_pkg;

	localparam int NUM_TIMERS = 16;
	// slot and entry are four bits wide, so at most sixteen entries are kept
	localparam int BANK  = (NUM_TIMERS < 16) ? NUM_TIMERS : 16;
	localparam int IDX_W = (BANK > 1) ? $clog2(BANK) : 1;

	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 48;

	typedef enum logic [2:0] {
		OP_TICK  = 3'd0,
		OP_ALLOC = 3'd1,
		OP_FREE  = 3'd2,
		OP_BIND  = 3'd3,
		OP_START = 3'd4
	} opcode_t;

	typedef enum logic [1:0] {
		KIND_DONE    = 2'd0,
		KIND_GRANT   = 2'd1,
		KIND_FAIL    = 2'd2,
		KIND_EXPIRED = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ENT_UNUSED  = 2'd0,
		ENT_ALLOC   = 2'd1,
		ENT_RUNNING = 2'd2
	} ent_state_t;

	typedef struct packed {
		logic load;       // latch the accepted word and start a new item
		logic tick_step;  // process the entry under the scan index for a tick
		logic alloc_step; // advance the allocation scan
		logic grant;      // take the entry under the scan index and report it
		logic finish;     // apply free/bind/start and send the final result
	} ctt_cmd_t;

	typedef struct packed {
		logic new_tick;   // word at the input is a tick
		logic new_alloc;  // word at the input is an allocate
		logic hit;        // running entry under the scan index reaches zero
		logic found;      // entry under the scan index is unused
		logic pend_v;     // an expiry result is held back
		logic last_idx;   // scan index is on the final entry
		logic out_free;   // output register can take a word this cycle
	} ctt_sts_t;

endpackage

@@ design/ctt_ctrl.sv @@
// ----------------------------------------------------------------------------
// ctt_ctrl
// Controller for the timer table: accepts one operation at a time and steps
// the datapath through the tick scan, the allocation scan and the final word.
// ----------------------------------------------------------------------------
module ctt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ctt_pkg::ctt_sts_t sts,
	output ctt_pkg::ctt_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_TICK   = 4'b0010,
		ST_ALLOC  = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (sts.new_tick) begin
						state_d = ST_TICK;
					end else if (sts.new_alloc) begin
						state_d = ST_ALLOC;
					end else begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_TICK: begin
				// a second expiry pushes the held one out, which needs the output
				if (!(sts.hit && sts.pend_v) || sts.out_free) begin
					cmd.tick_step = 1'b1;
					if (sts.last_idx) begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_ALLOC: begin
				if (sts.found) begin
					if (sts.out_free) begin
						cmd.grant = 1'b1;
						state_d   = ST_IDLE;
					end
				end else if (sts.last_idx) begin
					state_d = ST_FINISH;
				end else begin
					cmd.alloc_step = 1'b1;
				end
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ design/ctt_datapath.sv @@
// ----------------------------------------------------------------------------
// ctt_datapath
// Timer table storage, scan index, tick counter, held expiry result and the
// output register of the result stream.
// ----------------------------------------------------------------------------
module ctt_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [ctt_pkg::IN_DATA_W-1:0]      in_data,
	input  ctt_pkg::ctt_cmd_t                  cmd,
	output ctt_pkg::ctt_sts_t                  sts,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [ctt_pkg::OUT_DATA_W-1:0]     out_data,
	output logic [1:0]                         out_kind,
	output logic                               out_last
);

	// entry table
	ctt_pkg::ent_state_t ent_state_q [ctt_pkg::BANK];
	logic [31:0]         remaining_q [ctt_pkg::BANK];
	logic [7:0]          ent_byte_q  [ctt_pkg::BANK];
	logic [3:0]          ent_queue_q [ctt_pkg::BANK];

	logic [31:0] tick_total_q;

	// latched operation
	logic [2:0]  op_q;
	logic [3:0]  slot_q;
	logic [3:0]  queue_q;
	logic [7:0]  byte_q;
	logic [31:0] ticks_q;

	logic [ctt_pkg::IDX_W-1:0] idx_q;

	// held expiry result
	logic                      pend_v_q;
	logic [ctt_pkg::IDX_W-1:0] pend_idx_q;
	logic [7:0]                pend_byte_q;
	logic [3:0]                pend_queue_q;

	// output register
	logic        out_v_q;
	logic [1:0]  o_kind_q;
	logic [3:0]  o_entry_q;
	logic [7:0]  o_byte_q;
	logic [3:0]  o_queue_q;
	logic [31:0] o_now_q;
	logic        o_last_q;

	logic [2:0]                in_op;
	logic [ctt_pkg::IDX_W-1:0] slot_idx;
	logic                      slot_ok;
	logic                      running;
	logic [31:0]               dec;
	logic                      hit;
	logic                      found;
	logic                      out_free;

	logic        push;
	logic [1:0]  push_kind;
	logic [3:0]  push_entry;
	logic [7:0]  push_byte;
	logic [3:0]  push_queue;
	logic        push_last;

	assign in_op    = in_data[2:0];
	assign slot_idx = slot_q[ctt_pkg::IDX_W-1:0];
	assign slot_ok  = ({1'b0, slot_q} < 5'(ctt_pkg::BANK));
	assign running  = (ent_state_q[idx_q] == ctt_pkg::ENT_RUNNING);
	assign dec      = remaining_q[idx_q] - 32'd1;
	assign hit      = running && (dec == 32'd0);
	assign found    = (ent_state_q[idx_q] == ctt_pkg::ENT_UNUSED);
	assign out_free = !out_v_q || out_ready;

	always_comb begin
		sts           = '0;
		sts.new_tick  = (in_op == ctt_pkg::OP_TICK);
		sts.new_alloc = (in_op == ctt_pkg::OP_ALLOC);
		sts.hit       = hit;
		sts.found     = found;
		sts.pend_v    = pend_v_q;
		sts.last_idx  = (idx_q == ctt_pkg::IDX_W'(ctt_pkg::BANK - 1));
		sts.out_free  = out_free;
	end

	// result selection
	always_comb begin
		push       = 1'b0;
		push_kind  = ctt_pkg::KIND_DONE;
		push_entry = 4'd0;
		push_byte  = 8'd0;
		push_queue = 4'd0;
		push_last  = 1'b1;
		if (cmd.tick_step && hit && pend_v_q) begin
			push       = 1'b1;
			push_kind  = ctt_pkg::KIND_EXPIRED;
			push_entry = 4'(pend_idx_q);
			push_byte  = pend_byte_q;
			push_queue = pend_queue_q;
			push_last  = 1'b0;
		end else if (cmd.grant) begin
			push       = 1'b1;
			push_kind  = ctt_pkg::KIND_GRANT;
			push_entry = 4'(idx_q);
		end else if (cmd.finish) begin
			push = 1'b1;
			if (pend_v_q) begin
				push_kind  = ctt_pkg::KIND_EXPIRED;
				push_entry = 4'(pend_idx_q);
				push_byte  = pend_byte_q;
				push_queue = pend_queue_q;
			end else if (op_q == ctt_pkg::OP_ALLOC) begin
				push_kind = ctt_pkg::KIND_FAIL;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= in_data[2:0];
			slot_q  <= in_data[6:3];
			queue_q <= in_data[10:7];
			byte_q  <= in_data[18:11];
			ticks_q <= in_data[50:19];
		end
		if (cmd.tick_step && hit) begin
			pend_idx_q   <= idx_q;
			pend_byte_q  <= ent_byte_q[idx_q];
			pend_queue_q <= ent_queue_q[idx_q];
		end
		if (cmd.tick_step && running) begin
			remaining_q[idx_q] <= dec;
		end
		if (cmd.finish && slot_ok) begin
			if (op_q == ctt_pkg::OP_BIND) begin
				ent_byte_q[slot_idx]  <= byte_q;
				ent_queue_q[slot_idx] <= queue_q;
			end
			if (op_q == ctt_pkg::OP_START) begin
				remaining_q[slot_idx] <= ticks_q;
			end
		end
		if (push) begin
			o_kind_q  <= push_kind;
			o_entry_q <= push_entry;
			o_byte_q  <= push_byte;
			o_queue_q <= push_queue;
			o_now_q   <= tick_total_q;
			o_last_q  <= push_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ctt_pkg::BANK; i++) begin
				ent_state_q[i] <= ctt_pkg::ENT_UNUSED;
			end
			tick_total_q <= '0;
			idx_q        <= '0;
			pend_v_q     <= 1'b0;
			out_v_q      <= 1'b0;
		end else begin
			if (cmd.load) begin
				idx_q    <= '0;
				pend_v_q <= 1'b0;
				if (in_op == ctt_pkg::OP_TICK) begin
					tick_total_q <= tick_total_q + 32'd1;
				end
			end
			if (cmd.tick_step || cmd.alloc_step) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.tick_step && hit) begin
				ent_state_q[idx_q] <= ctt_pkg::ENT_ALLOC;
				pend_v_q           <= 1'b1;
			end
			if (cmd.grant) begin
				ent_state_q[idx_q] <= ctt_pkg::ENT_ALLOC;
			end
			if (cmd.finish && slot_ok) begin
				if (op_q == ctt_pkg::OP_FREE) begin
					ent_state_q[slot_idx] <= ctt_pkg::ENT_UNUSED;
				end
				if (op_q == ctt_pkg::OP_START) begin
					ent_state_q[slot_idx] <= ctt_pkg::ENT_RUNNING;
				end
			end
			if (push) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = {o_now_q, o_queue_q, o_byte_q, o_entry_q};
	assign out_kind  = o_kind_q;
	assign out_last  = o_last_q;

endmodule

@@ design/countdown_timer_table.sv @@
// ----------------------------------------------------------------------------
// countdown_timer_table
// Bank of sixteen software countdown timers with tick, allocate, free, bind
// and start operations, one operation word in, one or more result words out.
//
//   channel   dir  contents
//   s_axis    in   operation word: opcode, slot, queue_id, event_byte, ticks
//   m_axis    out  result word: entry, out_byte, out_queue, now; kind on
//                  tuser, last of the item on tlast
//
// a tick or allocate scans the table one entry per cycle, while not held as below;
// free, bind and start go straight to their final result.
// the next word is taken once the previous item has sent its final result
// into the output register, which may still wait on m_axis_tready.
// a stalled output holds the tick scan only when a second expiry is found.
// reset clears all entries to unused and the tick counter to zero at once.
// ----------------------------------------------------------------------------
module countdown_timer_table (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// opcode[2:0], slot[6:3], queue_id[10:7], event_byte[18:11], ticks[50:19]
	input  logic [ctt_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// entry[3:0], out_byte[11:4], out_queue[15:12], now[47:16]
	output logic [ctt_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	// kind[1:0]
	output logic [1:0]                        m_axis_tuser,
	output logic                              m_axis_tlast
);

	ctt_pkg::ctt_cmd_t cmd;
	ctt_pkg::ctt_sts_t sts;

	ctt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ctt_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (s_axis_tdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_kind  (m_axis_tuser),
		.out_last  (m_axis_tlast)
	);

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the countdown timer table. Operation words go in on
// s_axis in random bursts; a predictor keeps its own copy of the timer table
// and tick counter and queues the result words each operation should produce.
// Every result word on m_axis is checked against the oldest queued one, while
// the receiver stalls at random and once holds off long enough to back up
// the block. Directed cases, a full table and the hold-off run before random work.
// ----------------------------------------------------------------------------
module tb_top;
	import ctt_pkg::*;

	localparam int ITEM_TARGET   = 430;
	localparam int EXPIRY_TARGET = 60;
	localparam int HOLD_CYCLES   = 300;
	localparam int DRAIN_CYCLES  = 40;
	localparam int TIMEOUT       = 5_000_000;

	// opcodes the block does not know
	localparam logic [2:0] OP_RSVD_FIRST = 3'd5;
	localparam logic [2:0] OP_RSVD_LAST  = 3'd7;

	typedef struct packed {
		kind_t       kind;
		logic [3:0]  entry;
		logic [7:0]  evt;
		logic [3:0]  dest;
		logic [31:0] now;
		logic        last;
	} timer_result_t;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [1:0]            m_axis_tuser;
	logic                  m_axis_tlast;

	countdown_timer_table uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predicted table
	ent_state_t    tbl_state [BANK] = '{default: ENT_UNUSED};
	logic [31:0]   tbl_left  [BANK];
	logic [7:0]    tbl_evt   [BANK];
	logic [3:0]    tbl_dest  [BANK];
	bit            tbl_bound [BANK] = '{default: 1'b0};
	logic [31:0]   tick_count = '0;
	timer_result_t due_results [$];

	int items_sent    = 0;
	int unknown_sent  = 0;
	int expiries_due  = 0;
	int grants_due    = 0;
	int fails_due     = 0;
	int biggest_burst = 0;
	int results_seen  = 0;
	int mismatch_count = 0;
	int burst_left    = 0;

	int hold_asks    = 0;
	int holds_served = 0;
	int hold_left    = 0;
	int rx_mode      = 0;
	int rx_span      = 0;

	function automatic string fmt_result(timer_result_t r);
		return $sformatf("kind %0d entry %0d byte 0x%02h queue %0d now %0d last %0d",
			r.kind, r.entry, r.evt, r.dest, r.now, r.last);
	endfunction

	task automatic log_failure(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("ERROR @%0t: %s", $time, msg);
		end
	endtask

	function automatic int lowest_unused();
		for (int i = 0; i < BANK; i++) begin
			if (tbl_state[i] == ENT_UNUSED) begin
				return i;
			end
		end
		return -1;
	endfunction

	// advance the predicted table by one operation and queue its result words
	function automatic void apply_timer_op(input logic [2:0] op, input logic [3:0] slot,
			input logic [3:0] dest, input logic [7:0] evt, input logic [31:0] span);
		timer_result_t r;
		int last_hit;
		int burst;
		bit hit [BANK];
		r = '0;
		last_hit = -1;
		burst = 0;
		case (op)
			OP_TICK: begin
				tick_count = tick_count + 32'd1;
				for (int i = 0; i < BANK; i++) begin
					hit[i] = 1'b0;
					if (tbl_state[i] == ENT_RUNNING) begin
						tbl_left[i] = tbl_left[i] - 32'd1;
						if (tbl_left[i] == 32'd0) begin
							tbl_state[i] = ENT_ALLOC;
							hit[i] = 1'b1;
							last_hit = i;
						end
					end
				end
				for (int i = 0; i < BANK; i++) begin
					if (hit[i]) begin
						r.kind = KIND_EXPIRED;
						r.entry = 4'(i);
						r.evt = tbl_evt[i];
						r.dest = tbl_dest[i];
						r.now = tick_count;
						r.last = (i == last_hit);
						due_results.push_back(r);
						burst++;
					end
				end
				expiries_due += burst;
				if (burst > biggest_burst) begin
					biggest_burst = burst;
				end
			end
			OP_ALLOC: begin
				r.kind = KIND_FAIL;
				for (int i = 0; i < BANK; i++) begin
					if (tbl_state[i] == ENT_UNUSED) begin
						tbl_state[i] = ENT_ALLOC;
						r.kind = KIND_GRANT;
						r.entry = 4'(i);
						break;
					end
				end
				if (r.kind == KIND_GRANT) begin
					grants_due++;
				end else begin
					fails_due++;
				end
			end
			OP_FREE: tbl_state[slot] = ENT_UNUSED;
			OP_BIND: begin
				tbl_evt[slot] = evt;
				tbl_dest[slot] = dest;
				tbl_bound[slot] = 1'b1;
			end
			OP_START: begin
				tbl_left[slot] = span;
				tbl_state[slot] = ENT_RUNNING;
			end
			default: ;
		endcase
		// everything but an expiring tick gives a single word
		if (last_hit < 0) begin
			r.now = tick_count;
			r.last = 1'b1;
			due_results.push_back(r);
		end
	endfunction

	// offer one word in the current burst; entered and left at a falling edge
	task automatic send_op(input logic [2:0] op, input logic [3:0] slot,
			input logic [3:0] dest, input logic [7:0] evt, input logic [31:0] span);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if ($urandom_range(0, 3) != 0) begin
				s_axis_tvalid = 1'b0;
				repeat ($urandom_range(1, 10)) @(negedge clk);
			end
		end
		s_axis_tdata = {5'b0, span, evt, dest, slot, op};
		s_axis_tvalid = 1'b1;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		apply_timer_op(op, slot, dest, evt, span);
		if (op <= OP_START) begin
			items_sent++;
		end else begin
			unknown_sent++;
		end
		burst_left--;
		@(negedge clk);
	endtask

	// operations whose remaining fields are don't-care get random content
	task automatic send_ctl(input logic [2:0] op, input logic [3:0] slot);
		send_op(op, slot, 4'($urandom), 8'($urandom), $urandom);
	endtask

	task automatic test_directed();
		send_ctl(OP_TICK, 4'd0);
		send_ctl(OP_RSVD_FIRST, 4'hF);
		send_ctl(OP_RSVD_LAST, 4'h0);
		repeat (3) send_ctl(OP_ALLOC, 4'($urandom));
		send_ctl(OP_FREE, 4'd1);
		// the freed entry is the lowest unused one again
		send_ctl(OP_ALLOC, 4'($urandom));
		send_op(OP_BIND, 4'd0, 4'hF, 8'hFF, 32'h0000_0000);
		send_op(OP_BIND, 4'd1, 4'h0, 8'h00, 32'hFFFF_FFFF);
		send_op(OP_BIND, 4'd2, 4'h5, 8'hA5, 32'h5A5A_5A5A);
		send_op(OP_START, 4'd0, 4'h0, 8'h00, 32'd1);
		send_op(OP_START, 4'd1, 4'hF, 8'hFF, 32'd2);
		send_op(OP_START, 4'd2, 4'hA, 8'h5A, 32'hFFFF_FFFF);
		send_ctl(OP_TICK, 4'($urandom));
		send_ctl(OP_TICK, 4'($urandom));
		// zero count wraps round, so this one never runs out here
		send_op(OP_START, 4'd0, 4'h3, 8'hC3, 32'd0);
		send_ctl(OP_FREE, 4'd2);
		send_ctl(OP_TICK, 4'($urandom));
		send_op(OP_BIND, 4'hF, 4'hC, 8'h3C, $urandom);
		// start on an entry that was never allocated
		send_op(OP_START, 4'hF, 4'h6, 8'h96, 32'd1);
		send_op(OP_START, 4'd1, 4'h9, 8'h69, 32'd1);
		send_ctl(OP_TICK, 4'($urandom));
		send_ctl(OP_FREE, 4'd0);
		send_ctl(OP_FREE, 4'd1);
		send_ctl(OP_FREE, 4'hF);
	endtask

	task automatic test_full_table();
		while (lowest_unused() >= 0) begin
			send_ctl(OP_ALLOC, 4'($urandom));
		end
		send_ctl(OP_ALLOC, 4'($urandom));
		for (int i = 0; i < BANK; i++) begin
			send_op(OP_BIND, 4'(i), 4'($urandom), 8'($urandom), $urandom);
		end
		for (int i = 0; i < BANK; i++) begin
			send_op(OP_START, 4'(i), 4'($urandom), 8'($urandom), 32'd1);
		end
		// every entry runs out on the same tick
		send_ctl(OP_TICK, 4'($urandom));
		send_ctl(OP_ALLOC, 4'($urandom));
		for (int i = 0; i < BANK; i++) begin
			send_ctl(OP_FREE, 4'(i));
		end
	endtask

	task automatic test_backpressure();
		for (int i = 0; i < 6; i++) begin
			send_ctl(OP_ALLOC, 4'($urandom));
			send_op(OP_BIND, 4'(i), 4'($urandom), 8'($urandom), $urandom);
			send_op(OP_START, 4'(i), 4'($urandom), 8'($urandom), 32'd1);
		end
		hold_asks++;
		repeat (12) send_ctl(OP_TICK, 4'($urandom));
		for (int i = 0; i < 6; i++) begin
			send_ctl(OP_FREE, 4'(i));
		end
	endtask

	task automatic test_random();
		int g;
		logic [3:0] s;
		while (items_sent < ITEM_TARGET || expiries_due < EXPIRY_TARGET) begin
			s = 4'($urandom);
			if ($urandom_range(0, 9) < 6) begin
				// allocate, bind, start a short count and let it run down
				g = lowest_unused();
				if (g < 0) begin
					send_ctl(OP_FREE, s);
					g = s;
				end
				send_ctl(OP_ALLOC, 4'($urandom));
				send_op(OP_BIND, 4'(g), 4'($urandom), 8'($urandom), $urandom);
				send_op(OP_START, 4'(g), 4'($urandom), 8'($urandom),
					32'($urandom_range(1, 6)));
				repeat ($urandom_range(0, 5)) send_ctl(OP_TICK, 4'($urandom));
				if ($urandom_range(0, 4) < 2) begin
					send_ctl(OP_FREE, 4'(g));
				end
			end else begin
				case ($urandom_range(0, 7))
					0, 1: send_ctl(OP_TICK, s);
					2: send_ctl(OP_ALLOC, s);
					3: send_ctl(OP_FREE, s);
					4: send_op(OP_BIND, s, 4'($urandom), 8'($urandom), $urandom);
					5: begin
						// never let an entry run out before it has been bound
						if (!tbl_bound[s]) begin
							send_op(OP_BIND, s, 4'($urandom), 8'($urandom), $urandom);
						end
						send_op(OP_START, s, 4'($urandom), 8'($urandom),
							$urandom_range(0, 1) ? $urandom : 32'($urandom_range(1, 8)));
					end
					default: send_ctl(3'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST)), s);
				endcase
			end
		end
	endtask

	// receiver: random stall pattern, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_axis_tready = 1'b0;
			hold_left--;
		end else if (holds_served != hold_asks) begin
			holds_served++;
			hold_left = HOLD_CYCLES - 1;
			m_axis_tready = 1'b0;
		end else begin
			if (rx_span == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_span = $urandom_range(4, 60);
			end
			rx_span--;
			case (rx_mode)
				0: m_axis_tready = 1'b1;
				1: m_axis_tready = 1'($urandom_range(0, 1));
				2: m_axis_tready = ($urandom_range(0, 3) == 0);
				default: m_axis_tready = (rx_span % 3 != 0);
			endcase
		end
	end

	// each result word against the oldest predicted one
	always @(posedge clk) begin : result_check
		timer_result_t got;
		timer_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.kind = kind_t'(m_axis_tuser);
			got.entry = m_axis_tdata[3:0];
			got.evt = m_axis_tdata[11:4];
			got.dest = m_axis_tdata[15:12];
			got.now = m_axis_tdata[47:16];
			got.last = m_axis_tlast;
			results_seen++;
			if (due_results.size() == 0) begin
				log_failure({"word with nothing outstanding: ", fmt_result(got)});
			end else begin
				want = due_results.pop_front();
				if (got !== want) begin
					log_failure($sformatf("expected %s, got %s", fmt_result(want),
						fmt_result(got)));
				end
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_full_table();
		test_backpressure();
		test_random();
		s_axis_tvalid = 1'b0;
		while (due_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("ran %0d operations and %0d unknown opcodes, checked %0d result words",
			items_sent, unknown_sent, results_seen);
		$display("%0d expiries (up to %0d from one tick), %0d grants, %0d full-table refusals",
			expiries_due, biggest_burst, grants_due, fails_due);
		if (mismatch_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#(TIMEOUT);
		$display("timeout with %0d result words outstanding", due_results.size());
		$display("Test completed with failures");
		$finish;
	end

endmodule

@@ sim.f @@
design/ctt_pkg.sv
design/ctt_ctrl.sv
design/ctt_datapath.sv
design/countdown_timer_table.sv
dv/tb_top.sv
